### rtl/apss_pkg.sv
// Shared types and constants of the ATA PIO sector sequencer.
// Used by the front, queue, back, top level and checker; depends on nothing.
package apss_pkg;

    localparam int SECTOR_WORDS = 256;
    localparam int WORD_CNT_W   = $clog2(SECTOR_WORDS + 1);
    localparam int POLL_W       = 24;
    localparam int LBA_W        = 28;
    localparam int DATA_W       = 16;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 24'd1000000;

    localparam logic [2:0] OP_START_READ  = 3'd0;
    localparam logic [2:0] OP_START_WRITE = 3'd1;
    localparam logic [2:0] OP_STATUS      = 3'd2;
    localparam logic [2:0] OP_DEV_WORD    = 3'd3;
    localparam logic [2:0] OP_HOST_WORD   = 3'd4;

    localparam logic [7:0] ST_ERR = 8'h01;
    localparam logic [7:0] ST_DRQ = 8'h08;
    localparam logic [7:0] ST_RDY = 8'h40;
    localparam logic [7:0] ST_BSY = 8'h80;

    localparam logic [7:0] DRIVE_LBA_MASTER = 8'hE0;
    localparam logic [7:0] CMD_READ_SECTORS  = 8'h20;
    localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;
    localparam logic [7:0] CMD_FLUSH_CACHE   = 8'hE7;

    localparam logic [2:0] PORT_DATA    = 3'd0;
    localparam logic [2:0] PORT_COUNT   = 3'd2;
    localparam logic [2:0] PORT_LBA_LO  = 3'd3;
    localparam logic [2:0] PORT_LBA_MID = 3'd4;
    localparam logic [2:0] PORT_LBA_HI  = 3'd5;
    localparam logic [2:0] PORT_DRIVE   = 3'd6;
    localparam logic [2:0] PORT_CMD     = 3'd7;

    localparam logic [1:0] KIND_BUS  = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [2:0] OUT_SUCCESS    = 3'd0;
    localparam logic [2:0] OUT_NOT_READY  = 3'd1;
    localparam logic [2:0] OUT_DRQ_FAIL   = 3'd2;
    localparam logic [2:0] OUT_WRITE_FAIL = 3'd3;
    localparam logic [2:0] OUT_FLUSH_FAIL = 3'd4;

    typedef struct packed {
        logic [2:0]        operation;
        logic [LBA_W-1:0]  lba;
        logic [7:0]        status_byte;
        logic [DATA_W-1:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic              bus_write;
        logic [2:0]        port_offset;
        logic [DATA_W-1:0] value;
        logic [2:0]        outcome;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        JOB_STATUS,
        JOB_FINISH,
        JOB_PROGRAM,
        JOB_READ_START,
        JOB_READ_WORD,
        JOB_WRITE_WORD,
        JOB_FLUSH
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [LBA_W-1:0]  lba;
        logic [DATA_W-1:0] word;
        logic              flag;
        logic [2:0]        outcome;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_chan;

endpackage

### rtl/apss_front.sv
// Front part: accepts input items, runs the transfer phases and poll count,
// and emits one job per item that causes results. Depends on apss_pkg.
module apss_front import apss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_in_item          i_item,
    input  logic              i_cfg_we,
    input  logic [POLL_W-1:0] i_cfg_data,
    output t_job_chan         o_job
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_READY,
        PH_WAIT_DRQ,
        PH_READ_DATA,
        PH_WRITE_DATA,
        PH_WAIT_DONE,
        PH_WAIT_FLUSH
    } t_phase;

    typedef enum logic [1:0] {
        V_FAIL,
        V_PASS,
        V_AGAIN
    } t_verdict;

    t_phase              r_phase, n_phase;
    logic                r_is_write, n_is_write;
    logic [WORD_CNT_W-1:0] r_words, n_words;
    logic [POLL_W-1:0]   r_polls, n_polls;
    logic [LBA_W-1:0]    r_lba, n_lba;
    logic [POLL_W-1:0]   r_poll_limit;

    t_verdict            verdict;
    logic [POLL_W-1:0]   judge_polls;
    logic [7:0]          mask;
    logic [WORD_CNT_W-1:0] words_dec;

    always_comb begin
        mask = (r_phase == PH_WAIT_DRQ) ? ST_DRQ : ST_RDY;
        judge_polls = r_polls;
        if ((i_item.status_byte & ST_ERR) != 8'h00) begin
            verdict = V_FAIL;
        end else if (((i_item.status_byte & ST_BSY) == 8'h00) &&
                     ((i_item.status_byte & mask) != 8'h00)) begin
            verdict = V_PASS;
        end else if (r_polls <= POLL_W'(1)) begin
            verdict = V_FAIL;
            judge_polls = '0;
        end else begin
            verdict = V_AGAIN;
            judge_polls = r_polls - POLL_W'(1);
        end
    end

    assign words_dec = r_words - WORD_CNT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_is_write = r_is_write;
        n_words    = r_words;
        n_polls    = r_polls;
        n_lba      = r_lba;
        o_job.valid       = 1'b0;
        o_job.job.kind    = JOB_STATUS;
        o_job.job.lba     = r_lba;
        o_job.job.word    = i_item.data_word;
        o_job.job.flag    = r_is_write;
        o_job.job.outcome = OUT_SUCCESS;
        if (i_accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_item.operation == OP_START_READ ||
                        i_item.operation == OP_START_WRITE) begin
                        n_lba      = i_item.lba;
                        n_is_write = (i_item.operation == OP_START_WRITE);
                        n_phase    = PH_WAIT_READY;
                        n_polls    = r_poll_limit;
                        o_job.valid = 1'b1;
                    end
                end
                PH_WAIT_READY, PH_WAIT_DRQ, PH_WAIT_DONE, PH_WAIT_FLUSH: begin
                    if (i_item.operation == OP_STATUS) begin
                        o_job.valid = 1'b1;
                        n_polls = judge_polls;
                        case (verdict)
                            V_AGAIN: o_job.job.kind = JOB_STATUS;
                            V_FAIL: begin
                                o_job.job.kind = JOB_FINISH;
                                n_phase = PH_IDLE;
                                case (r_phase)
                                    PH_WAIT_READY: o_job.job.outcome = OUT_NOT_READY;
                                    PH_WAIT_DRQ:   o_job.job.outcome = OUT_DRQ_FAIL;
                                    PH_WAIT_DONE:  o_job.job.outcome = OUT_WRITE_FAIL;
                                    default:       o_job.job.outcome = OUT_FLUSH_FAIL;
                                endcase
                            end
                            default: begin
                                case (r_phase)
                                    PH_WAIT_READY: begin
                                        o_job.job.kind = JOB_PROGRAM;
                                        n_phase = PH_WAIT_DRQ;
                                        n_polls = r_poll_limit;
                                    end
                                    PH_WAIT_DRQ: begin
                                        n_words = WORD_CNT_W'(SECTOR_WORDS);
                                        o_job.job.kind = JOB_READ_START;
                                        if (r_is_write) begin
                                            o_job.valid = 1'b0;
                                            n_phase = PH_WRITE_DATA;
                                        end else begin
                                            n_phase = PH_READ_DATA;
                                        end
                                    end
                                    PH_WAIT_DONE: begin
                                        o_job.job.kind = JOB_FLUSH;
                                        n_phase = PH_WAIT_FLUSH;
                                        n_polls = r_poll_limit;
                                    end
                                    default: begin
                                        o_job.job.kind = JOB_FINISH;
                                        n_phase = PH_IDLE;
                                    end
                                endcase
                            end
                        endcase
                    end
                end
                PH_READ_DATA: begin
                    if (i_item.operation == OP_DEV_WORD) begin
                        o_job.valid    = 1'b1;
                        o_job.job.kind = JOB_READ_WORD;
                        o_job.job.flag = (words_dec == '0);
                        n_words = words_dec;
                        if (words_dec == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_WRITE_DATA: begin
                    if (i_item.operation == OP_HOST_WORD) begin
                        o_job.valid    = 1'b1;
                        o_job.job.kind = JOB_WRITE_WORD;
                        o_job.job.flag = (words_dec == '0);
                        n_words = words_dec;
                        if (words_dec == '0) begin
                            n_phase = PH_WAIT_DONE;
                            n_polls = r_poll_limit;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_is_write   <= 1'b0;
            r_words      <= '0;
            r_polls      <= '0;
            r_lba        <= '0;
            r_poll_limit <= POLL_LIMIT_RESET;
        end else begin
            r_phase    <= n_phase;
            r_is_write <= n_is_write;
            r_words    <= n_words;
            r_polls    <= n_polls;
            r_lba      <= n_lba;
            if (i_cfg_we) begin
                r_poll_limit <= i_cfg_data;
            end
        end
    end

endmodule

### rtl/apss_queue.sv
// Two-entry job queue between the front and back parts.
// Depends on apss_pkg for the job type.
module apss_queue import apss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_chan i_push,
    input  logic      i_pop,
    output logic      o_full,
    output t_job_chan o_head
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push_en;
    logic       pop_en;

    assign o_full      = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.job   = r_mem[r_rptr];
    assign push_en = i_push.valid && !o_full;
    assign pop_en  = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push_en) begin
                r_wptr <= !r_wptr;
            end
            if (pop_en) begin
                r_rptr <= !r_rptr;
            end
            case ({push_en, pop_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/apss_back.sv
// Back part: expands each job into its bus accesses, host words and completion,
// one result per cycle into the output register when not stalled. Uses apss_pkg.
module apss_back import apss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_chan i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_job       r_job;
    logic       r_busy;
    logic [2:0] r_step;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  res;
    logic       emit;

    assign o_pop       = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign emit        = r_busy && (!r_out_valid || !i_out_stall);

    always_comb begin
        res.kind        = KIND_BUS;
        res.bus_write   = 1'b0;
        res.port_offset = PORT_CMD;
        res.value       = '0;
        res.outcome     = OUT_SUCCESS;
        res.last        = 1'b1;
        case (r_job.kind)
            JOB_FINISH: begin
                res.kind        = KIND_DONE;
                res.port_offset = PORT_DATA;
                res.outcome     = r_job.outcome;
            end
            JOB_PROGRAM: begin
                res.bus_write = 1'b1;
                res.last      = 1'b0;
                case (r_step)
                    3'd0: begin
                        res.port_offset = PORT_DRIVE;
                        res.value = {8'h00, DRIVE_LBA_MASTER | {4'h0, r_job.lba[27:24]}};
                    end
                    3'd1: begin
                        res.port_offset = PORT_COUNT;
                        res.value = DATA_W'(1);
                    end
                    3'd2: begin
                        res.port_offset = PORT_LBA_LO;
                        res.value = {8'h00, r_job.lba[7:0]};
                    end
                    3'd3: begin
                        res.port_offset = PORT_LBA_MID;
                        res.value = {8'h00, r_job.lba[15:8]};
                    end
                    3'd4: begin
                        res.port_offset = PORT_LBA_HI;
                        res.value = {8'h00, r_job.lba[23:16]};
                    end
                    3'd5: begin
                        res.port_offset = PORT_CMD;
                        res.value = {8'h00, r_job.flag ? CMD_WRITE_SECTORS
                                                       : CMD_READ_SECTORS};
                    end
                    default: begin
                        res.bus_write = 1'b0;
                        res.last      = 1'b1;
                    end
                endcase
            end
            JOB_READ_START: begin
                res.port_offset = PORT_DATA;
            end
            JOB_READ_WORD: begin
                res.port_offset = PORT_DATA;
                if (r_step == 3'd0) begin
                    res.kind  = KIND_HOST;
                    res.value = r_job.word;
                    res.last  = 1'b0;
                end else if (r_job.flag) begin
                    res.kind = KIND_DONE;
                end
            end
            JOB_WRITE_WORD: begin
                if (r_step == 3'd0) begin
                    res.bus_write   = 1'b1;
                    res.port_offset = PORT_DATA;
                    res.value       = r_job.word;
                    res.last        = !r_job.flag;
                end
            end
            JOB_FLUSH: begin
                if (r_step == 3'd0) begin
                    res.bus_write = 1'b1;
                    res.value     = {8'h00, CMD_FLUSH_CACHE};
                    res.last      = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_head.valid) begin
            r_job <= i_head.job;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_busy) begin
                r_busy <= i_head.valid;
                r_step <= 3'd0;
            end else if (emit) begin
                r_step <= r_step + 3'd1;
                if (res.last) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/ata_pio_sector_sequencer.sv
// Top level of the ATA PIO LBA28 sector sequencer.
// Instantiates apss_front, apss_queue and apss_back; uses apss_pkg.
//
// Usage: input items (start read/write, status byte, device word, host word)
// enter on i_in_valid/o_in_stall/i_in_item; each is a transfer when valid is
// high and stall low. Results leave on o_out_valid/i_out_stall/o_out_item,
// at most one per cycle, the last of an item's results flagged by last.
// The poll limit is written on i_cfg_valid/o_cfg_ready/i_cfg_data; the user
// must write it only while idle, as the block does no check of this; ready is
// always high. The first result of an item passes through the queue, the back
// part's job register and the output register; the back part takes a new job
// only after it has emitted every result of the job before.
// The front part updates the transfer phase at the transfer itself and
// only stalls when the two-entry job queue is full, so it keeps accepting
// while the output waits on i_out_stall; a stalled result holds unchanged.
// Reset (synchronous, active low) returns to idle with the poll limit at
// 1000000, empties the queue and drops any pending result.
module ata_pio_sector_sequencer import apss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [POLL_W-1:0] i_cfg_data
);

    t_job_chan push;
    t_job_chan head;
    logic      q_full;
    logic      pop;
    logic      accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;

    apss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_job      (push)
    );

    apss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    apss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### rtl/apss_checker.sv
// Port-level checker for the sequencer, bound to the top level.
// Depends on apss_pkg.
module apss_checker import apss_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_DONE |->
            o_out_item.last && o_out_item.value == '0)
        else $error("completion not last or carries data");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ata_pio_sector_sequencer apss_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
